/* sv/hsort_pkg.sv */
// Package for the heap sort engine: word types, sizes and sequencer states.
package hsort_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    // One input word: an element of the set and the close-of-set mark.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_word;

    // One output word: the next element in ascending order plus marks.
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } t_out_word;

    // Status from the shared index/compare unit.
    typedef struct packed {
        logic lc_ok;    // left child lies inside the heap
        logic rc_ok;    // right child lies inside the heap
        logic a_gt_b;   // signed a > b
    } t_unit_flags;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLD_NEXT,
        S_SD_CUR,
        S_SD_L,
        S_SD_R,
        S_SD_C,
        S_EXT_NEXT,
        S_EXT_RD,
        S_EXT_SWAP,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

endpackage

/* sv/hsort_unit.sv */
// Shared unit: child indices of a heap node and one signed compare.
module hsort_unit #(
    parameter int MAX_ITEMS = hsort_pkg::MAX_ITEMS_DEF
) (
    input  logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] i_node,
    input  logic [$clog2(MAX_ITEMS + 1)-1:0]                     i_size,
    input  logic signed [hsort_pkg::DATA_W-1:0]                  i_a,
    input  logic signed [hsort_pkg::DATA_W-1:0]                  i_b,
    output logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] o_lc,
    output logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] o_rc,
    output hsort_pkg::t_unit_flags                               o_flags
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = CW + 1;   // holds 2*node + 2

    logic [IW-1:0] lc_w;
    logic [IW-1:0] rc_w;
    logic [IW-1:0] size_w;

    assign lc_w   = (IW'(i_node) << 1) + IW'(1);
    assign rc_w   = (IW'(i_node) << 1) + IW'(2);
    assign size_w = IW'(i_size);

    // index only meaningful when the matching _ok flag is set
    assign o_lc = lc_w[AW-1:0];
    assign o_rc = rc_w[AW-1:0];

    assign o_flags.lc_ok  = (lc_w < size_w);
    assign o_flags.rc_ok  = (rc_w < size_w);
    assign o_flags.a_gt_b = (i_a > i_b);

endmodule

/* sv/heap_sort_engine.sv */
// Heap sort engine top level: element store, sort sequencer and output register.
//
//  channel | valid   | stall   | payload                                | dir
//  --------+---------+---------+----------------------------------------+-----
//  input   | i_valid | o_stall | i_data  (value, last)                  | in
//  output  | o_valid | i_stall | o_data  (sorted_value, last_out, ovf)  | out
//
// Words load one per cycle while o_stall is low; words past MAX_ITEMS are dropped
// and flag overflow on the whole set. The word marked last closes the set; o_stall
// stays high until its final result is in the output register. Each sift-down level
// reads the left child, reads the right child, then compares and writes; each result
// is read from the store, then loaded into the output register. Reset clears count,
// dropped mark, state and output valid; i_stall holds the output register and S_OUT_RD.

module heap_sort_engine #(
    parameter int MAX_ITEMS = hsort_pkg::MAX_ITEMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  hsort_pkg::t_in_word  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output hsort_pkg::t_out_word o_data
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int DW = hsort_pkg::DATA_W;

    // element store, registered read
    logic signed [DW-1:0] mem [MAX_ITEMS];
    logic signed [DW-1:0] r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic signed [DW-1:0] mem_wd;
    logic [AW-1:0]        mem_ra;

    hsort_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_count,   n_count;    // words held in this set
    logic                 r_dropped, n_dropped;
    logic [CW-1:0]        r_n,       n_n;        // size of the closed set
    logic                 r_ovf,     n_ovf;
    logic [CW-1:0]        r_k,       n_k;        // build / extract loop count
    logic                 r_extract, n_extract;  // 1 once in extraction phase
    logic [AW-1:0]        r_node,    n_node;     // hole of the current sift
    logic [CW-1:0]        r_size,    n_size;     // heap size of the current sift
    logic signed [DW-1:0] r_cur,     n_cur;      // value being sifted down
    logic signed [DW-1:0] r_best,    n_best;     // larger of cur and left child
    logic                 r_best_l,  n_best_l;   // best came from the left child
    logic signed [DW-1:0] r_tmp,     n_tmp;      // old root during a swap
    logic [CW-1:0]        r_i,       n_i;        // output index
    hsort_pkg::t_out_word r_out,     n_out;
    logic                 r_oval,    n_oval;

    // shared index / compare unit
    logic [AW-1:0]          lc, rc;
    logic signed [DW-1:0]   cmp_b;
    hsort_pkg::t_unit_flags uf;

    hsort_unit #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_unit (
        .i_node  (r_node),
        .i_size  (r_size),
        .i_a     (r_rdata),
        .i_b     (cmp_b),
        .o_lc    (lc),
        .o_rc    (rc),
        .o_flags (uf)
    );

    // right-child compare goes against the running best, otherwise against cur
    assign cmp_b = (r_state == hsort_pkg::S_SD_C) ? r_best : r_cur;

    logic          in_acc;
    logic          out_free;   // output register empty next cycle
    logic          full;
    logic [CW-1:0] k_m1;
    logic          take_r;

    assign o_stall  = (r_state != hsort_pkg::S_IDLE);
    assign in_acc   = i_valid && (r_state == hsort_pkg::S_IDLE);
    assign out_free = !r_oval || !i_stall;
    assign full     = (r_count == CW'(MAX_ITEMS));
    assign k_m1     = r_k - CW'(1);
    assign take_r   = uf.rc_ok && uf.a_gt_b;

    assign o_valid = r_oval;
    assign o_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hsort_pkg::S_IDLE: begin
                if (in_acc && i_data.last) n_state = hsort_pkg::S_BLD_NEXT;
            end
            hsort_pkg::S_BLD_NEXT: begin
                n_state = (r_k == '0) ? hsort_pkg::S_EXT_NEXT : hsort_pkg::S_SD_CUR;
            end
            hsort_pkg::S_SD_CUR: n_state = hsort_pkg::S_SD_L;
            hsort_pkg::S_SD_L: begin
                if (uf.lc_ok) begin
                    n_state = hsort_pkg::S_SD_R;
                end else begin
                    n_state = r_extract ? hsort_pkg::S_EXT_NEXT : hsort_pkg::S_BLD_NEXT;
                end
            end
            hsort_pkg::S_SD_R: n_state = hsort_pkg::S_SD_C;
            hsort_pkg::S_SD_C: begin
                if (take_r || r_best_l) begin
                    n_state = hsort_pkg::S_SD_L;
                end else begin
                    n_state = r_extract ? hsort_pkg::S_EXT_NEXT : hsort_pkg::S_BLD_NEXT;
                end
            end
            hsort_pkg::S_EXT_NEXT: begin
                n_state = (r_k <= CW'(1)) ? hsort_pkg::S_OUT_RD : hsort_pkg::S_EXT_RD;
            end
            hsort_pkg::S_EXT_RD:   n_state = hsort_pkg::S_EXT_SWAP;
            hsort_pkg::S_EXT_SWAP: n_state = hsort_pkg::S_SD_L;
            hsort_pkg::S_OUT_RD: begin
                if (out_free) n_state = hsort_pkg::S_OUT_LD;
            end
            hsort_pkg::S_OUT_LD: begin
                n_state = (r_i + CW'(1) == r_n) ? hsort_pkg::S_IDLE : hsort_pkg::S_OUT_RD;
            end
            default: n_state = hsort_pkg::S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        n_n       = r_n;
        n_ovf     = r_ovf;
        n_k       = r_k;
        n_extract = r_extract;
        n_node    = r_node;
        n_size    = r_size;
        n_cur     = r_cur;
        n_best    = r_best;
        n_best_l  = r_best_l;
        n_tmp     = r_tmp;
        n_i       = r_i;
        n_out     = r_out;
        n_oval    = (r_oval && !i_stall) ? 1'b0 : r_oval;
        mem_we    = 1'b0;
        mem_wa    = r_node;
        mem_wd    = r_cur;
        mem_ra    = lc;

        unique case (r_state)
            hsort_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (!full) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_count[AW-1:0];
                        mem_wd  = i_data.value;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_data.last) begin
                        // set closes: latch its size and overflow mark
                        n_n       = full ? r_count : r_count + CW'(1);
                        n_ovf     = r_dropped || full;
                        n_k       = (full ? r_count : r_count + CW'(1)) >> 1;
                        n_extract = 1'b0;
                        n_count   = '0;
                        n_dropped = 1'b0;
                    end
                end
            end
            hsort_pkg::S_BLD_NEXT: begin
                if (r_k == '0) begin
                    n_extract = 1'b1;
                    n_k       = r_n;
                end else begin
                    mem_ra = k_m1[AW-1:0];
                    n_node = k_m1[AW-1:0];
                    n_size = r_n;
                    n_k    = k_m1;
                end
            end
            hsort_pkg::S_SD_CUR: n_cur = r_rdata;
            hsort_pkg::S_SD_L: begin
                mem_ra = lc;
                if (!uf.lc_ok) begin
                    // leaf reached: drop the value into the hole
                    mem_we = 1'b1;
                end
            end
            hsort_pkg::S_SD_R: begin
                mem_ra   = rc;
                n_best   = uf.a_gt_b ? r_rdata : r_cur;
                n_best_l = uf.a_gt_b;
            end
            hsort_pkg::S_SD_C: begin
                mem_we = 1'b1;
                if (take_r) begin
                    mem_wd = r_rdata;
                    n_node = rc;
                end else if (r_best_l) begin
                    mem_wd = r_best;
                    n_node = lc;
                end
            end
            hsort_pkg::S_EXT_NEXT: begin
                mem_ra = '0;
                n_i    = '0;
            end
            hsort_pkg::S_EXT_RD: begin
                n_tmp  = r_rdata;
                mem_ra = k_m1[AW-1:0];
            end
            hsort_pkg::S_EXT_SWAP: begin
                // old root goes to the end, old end is sifted from the root
                n_cur  = r_rdata;
                mem_we = 1'b1;
                mem_wa = k_m1[AW-1:0];
                mem_wd = r_tmp;
                n_node = '0;
                n_size = k_m1;
                n_k    = k_m1;
            end
            hsort_pkg::S_OUT_RD: begin
                mem_ra = r_i[AW-1:0];
            end
            hsort_pkg::S_OUT_LD: begin
                n_out.sorted_value = r_rdata;
                n_out.last_out     = (r_i + CW'(1) == r_n);
                n_out.overflow     = r_ovf;
                n_oval             = 1'b1;
                n_i                = r_i + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hsort_pkg::S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_oval    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_oval    <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_ovf    <= n_ovf;
        r_k      <= n_k;
        r_extract <= n_extract;
        r_node   <= n_node;
        r_size   <= n_size;
        r_cur    <= n_cur;
        r_best   <= n_best;
        r_best_l <= n_best_l;
        r_tmp    <= n_tmp;
        r_i      <= n_i;
        r_out    <= n_out;
    end

endmodule
